@@ rtl/smo_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package smo_pkg;

	localparam int WINDOW_LEN_DEF  = 7;
	localparam int SAMPLE_BITS_DEF = 16;

endpackage

`default_nettype wire

@@ rtl/smo_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module smo_cell import smo_pkg::*; #(
	parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int IDX         = 0
) (
	input  wire logic                                  clk,
	input  wire logic                                  shift_en,
	input  wire logic                                  s1_en,
	input  wire logic [SAMPLE_BITS-1:0]                din,
	input  wire logic [WINDOW_LEN-1:0][SAMPLE_BITS-1:0] win,
	output logic      [SAMPLE_BITS-1:0]                val,
	output logic                                       med_s1,
	output logic      [SAMPLE_BITS-1:0]                val_s1
);

	localparam int RW = $clog2(WINDOW_LEN);
	localparam int MED_RANK = (WINDOW_LEN - 1) / 2;
	localparam logic [RW-1:0] MED_RANK_V = RW'(MED_RANK);

	logic [SAMPLE_BITS-1:0] val_q;
	logic [RW-1:0]          rank;

	// this cell's sample moves on to its older neighbor on every accepted item
	always_ff @(posedge clk) begin
		if (shift_en) begin
			val_q <= din;
		end
	end

	assign val = val_q;

	// rank among the window, equal samples ordered by position
	always_comb begin
		rank = '0;
		for (int j = 0; j < WINDOW_LEN; j++) begin
			if (j != IDX) begin
				if (($signed(win[j]) < $signed(val_q)) ||
				    ((win[j] == val_q) && (j < IDX))) begin
					rank = rank + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en) begin
			med_s1 <= (rank == MED_RANK_V);
			val_s1 <= val_q;
		end
	end

endmodule

`default_nettype wire

@@ rtl/sliding_median_of_seven.sv @@
`timescale 1ns / 1ps
`default_nettype none
// running median over the last WINDOW_LEN samples, one cell per window slot
// result goes through window, rank and output registers; m_tready low can stall input
// throughput: one item per cycle, set by the cell row shifting once per accepted item
// the first WINDOW_LEN-1 items of a stream give no result
// reset clears fill count and stage valids; window contents are not cleared

module sliding_median_of_seven import smo_pkg::*; #(
	parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // sample
	input  wire logic [0:0]                          s_tuser,  // stream_start
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata   // median
);

	localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int CW = $clog2(WINDOW_LEN + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(WINDOW_LEN);

	logic [WINDOW_LEN-1:0][SAMPLE_BITS-1:0] win;
	logic [WINDOW_LEN-1:0][SAMPLE_BITS-1:0] win_in;
	logic [WINDOW_LEN-1:0][SAMPLE_BITS-1:0] val_s1;
	logic [WINDOW_LEN-1:0]                  med_s1;

	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          cnt_base;
	logic [CW-1:0]          cnt_next;
	logic                   pend_q;
	logic                   valid_s1;
	logic                   m_valid_q;
	logic [SAMPLE_BITS-1:0] median_q;
	logic [SAMPLE_BITS-1:0] med_sel;
	logic                   acc;
	logic                   win_en;
	logic                   s1_en;
	logic                   out_en;

	assign out_en   = !m_valid_q || m_tready;
	assign s1_en    = !valid_s1 || out_en;
	assign win_en   = !pend_q || s1_en;
	assign s_tready = win_en;
	assign acc      = s_tvalid && win_en;

	assign cnt_base = s_tuser[0] ? '0 : cnt_q;
	assign cnt_next = (cnt_base < FULL_CNT) ? cnt_base + 1'b1 : FULL_CNT;

	// newest sample enters the top cell, older ones move down
	always_comb begin
		for (int i = 0; i < WINDOW_LEN - 1; i++) begin
			win_in[i] = win[i+1];
		end
		win_in[WINDOW_LEN-1] = s_tdata[SAMPLE_BITS-1:0];
	end

	for (genvar g = 0; g < WINDOW_LEN; g++) begin : g_cell
		smo_cell #(
			.WINDOW_LEN (WINDOW_LEN),
			.SAMPLE_BITS(SAMPLE_BITS),
			.IDX        (g)
		) u_cell (
			.clk     (clk),
			.shift_en(acc),
			.s1_en   (s1_en),
			.din     (win_in[g]),
			.win     (win),
			.val     (win[g]),
			.med_s1  (med_s1[g]),
			.val_s1  (val_s1[g])
		);
	end

	always_comb begin
		med_sel = '0;
		for (int i = 0; i < WINDOW_LEN; i++) begin
			med_sel = med_sel | (val_s1[i] & {SAMPLE_BITS{med_s1[i]}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			pend_q    <= 1'b0;
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				cnt_q <= cnt_next;
			end
			if (win_en) begin
				pend_q <= acc && (cnt_next == FULL_CNT);
			end
			if (s1_en) begin
				valid_s1 <= pend_q;
			end
			if (out_en) begin
				m_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			median_q <= med_sel;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = DW'(median_q);

	a_one_median: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot(med_s1))
		else $error("median select not one-hot");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("fill count out of range");

	a_start_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && s_tuser[0]) |=> !pend_q)
		else $error("stream start produced a result");

	a_window_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q && !s1_en) |=> (pend_q && $stable(win)))
		else $error("window changed while stalled");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import smo_pkg::*;

	localparam int WIN         = WINDOW_LEN_DEF;
	localparam int SBITS       = SAMPLE_BITS_DEF;
	localparam int DATA_W      = ((SBITS + 7) / 8) * 8;
	localparam int MID_RANK    = (WIN - 1) / 2;
	localparam int N_ITEMS     = 500;
	localparam int HOLD_START  = 150;
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_WAIT  = 20;

	typedef logic signed [SBITS-1:0] sample_t;

	typedef struct {
		sample_t sample;
		logic    start;
	} sample_item_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata  = '0;  // sample
	logic [0:0]        s_tuser  = '0;  // stream_start
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;        // median

	sample_item_t pending_items[$];
	sample_t      median_expected[$];
	sample_t      window_hist[WIN];
	int           stream_fill = 0;
	bit           failed = 0;
	int           n_queued = 0;

	sliding_median_of_seven DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic sample_t window_median();
		sample_t sorted[WIN];
		sample_t key;
		int j;
		sorted = window_hist;
		for (int i = 1; i < WIN; i++) begin
			key = sorted[i];
			j = i - 1;
			while (j >= 0 && sorted[j] > key) begin
				sorted[j + 1] = sorted[j];
				j--;
			end
			sorted[j + 1] = key;
		end
		return sorted[MID_RANK];
	endfunction

	task automatic take_sample(input sample_t s, input logic start);
		if (start) begin
			foreach (window_hist[i])
				window_hist[i] = '0;
			stream_fill = 0;
		end
		for (int i = 0; i + 1 < WIN; i++)
			window_hist[i] = window_hist[i + 1];
		window_hist[WIN-1] = s;
		if (stream_fill < WIN)
			stream_fill++;
		if (stream_fill == WIN)
			median_expected.push_back(window_median());
	endtask

	task automatic queue_sample(input sample_t s, input logic start);
		sample_item_t it;
		it.sample = s;
		it.start = start;
		pending_items.push_back(it);
		n_queued++;
	endtask

	function automatic sample_t pick_sample();
		sample_t v;
		case ($urandom_range(0, 9))
			0: v = 16'sh7fff;
			1: v = 16'sh8000;
			2, 3, 4: v = sample_t'(int'($urandom_range(0, 8)) - 4);
			default: v = sample_t'($urandom);
		endcase
		return v;
	endfunction

	// sender: bursts of items with random gaps
	int burst_left = 0;
	int gap_left = 0;
	sample_item_t next_item;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				take_sample(sample_t'(s_tdata[SBITS-1:0]), s_tuser[0]);
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					next_item = pending_items.pop_front();
					s_tdata  <= DATA_W'(next_item.sample);
					s_tuser  <= next_item.start;
					s_tvalid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 30);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver ready: long hold-off once, otherwise a changing stall pattern
	int rx_cycles = 0;
	int stall_mode = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			rx_cycles++;
			if (rx_cycles % 50 == 0)
				stall_mode = $urandom_range(0, 2);
			if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_CYCLES)
				m_tready <= 1'b0;
			else if (stall_mode == 0)
				m_tready <= 1'b1;
			else if (stall_mode == 1)
				m_tready <= ($urandom_range(0, 1) == 1);
			else
				m_tready <= ($urandom_range(0, 7) != 0);
		end
	end

	// result checker
	sample_t want_median;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (median_expected.size() == 0) begin
				$error("median: unexpected item, actual %0d", $signed(m_tdata[SBITS-1:0]));
				failed = 1;
			end else begin
				want_median = median_expected.pop_front();
				if (m_tdata[SBITS-1:0] !== want_median) begin
					$error("median: expected %0d, actual %0d", want_median,
						$signed(m_tdata[SBITS-1:0]));
					failed = 1;
				end
			end
		end
	end

	initial begin
		int len;
		logic start;

		// no start flag after reset, extremes and mixed signs
		queue_sample(16'sh7fff, 1'b0);
		queue_sample(16'sh8000, 1'b0);
		queue_sample(16'sh0000, 1'b0);
		queue_sample(-16'sd1, 1'b0);
		queue_sample(16'sd1, 1'b0);
		queue_sample(16'sh7fff, 1'b0);
		queue_sample(16'sh8000, 1'b0);
		queue_sample(16'sh8000, 1'b0);
		queue_sample(16'sh8000, 1'b0);
		// short stream cut off by a new start
		queue_sample(16'sh5555, 1'b1);
		queue_sample(16'shaaaa, 1'b0);
		queue_sample(16'sh7fff, 1'b0);
		// duplicates throughout
		queue_sample(16'sh1234, 1'b1);
		for (int i = 0; i < 6; i++)
			queue_sample(16'sh1234, 1'b0);
		queue_sample(-16'sd1, 1'b0);
		queue_sample(16'sh0000, 1'b0);
		queue_sample(16'sh1234, 1'b0);

		while (n_queued < N_ITEMS) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, WIN - 1)
			                                  : $urandom_range(WIN, 60);
			start = ($urandom_range(0, 7) != 0);
			for (int i = 0; i < len; i++)
				queue_sample(pick_sample(), (i == 0) ? start : 1'b0);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() > 0 || s_tvalid || median_expected.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (!failed && median_expected.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	initial begin
		#200us;
		$display("testbench NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
rtl/smo_pkg.sv
rtl/smo_cell.sv
rtl/sliding_median_of_seven.sv
tb/sv/testbench.sv
